/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset, and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks the consequent in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Checks the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/dmp_pkg.sv */
package dmp_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PWM_CNT_W = 5;

    typedef enum logic [3:0] {
        CMD_TICK          = 4'd0,
        CMD_POLL          = 4'd1,
        CMD_OPEN          = 4'd2,
        CMD_CLOSE         = 4'd3,
        CMD_SUSPEND       = 4'd4,
        CMD_RESUME        = 4'd5,
        CMD_SET_MODE      = 4'd6,
        CMD_SET_INTENSITY = 4'd7,
        CMD_STATUS        = 4'd8
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_INTENSITY     = 3'd0,
        REG_OPEN_MODE          = 3'd1,
        REG_OPEN_AUTO_ADVANCE  = 3'd2,
        REG_HALF_PERIOD_TICKS  = 3'd3,
        REG_FULL_PERIOD_TICKS  = 3'd4,
        REG_AUTO_ADVANCE_TICKS = 3'd5
    } reg_idx_t;

    localparam logic [3:0] MODE_STEP  = 4'd1;
    localparam logic [3:0] MODE_ALT   = 4'd2;
    localparam logic [3:0] MODE_PULSE = 4'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    localparam logic [4:0]  RST_OPEN_INTENSITY     = 5'd10;
    localparam logic [3:0]  RST_OPEN_MODE          = 4'd1;
    localparam logic        RST_OPEN_AUTO_ADVANCE  = 1'b0;
    localparam logic [15:0] RST_HALF_PERIOD_TICKS  = 16'd50;
    localparam logic [15:0] RST_FULL_PERIOD_TICKS  = 16'd100;
    localparam logic [15:0] RST_AUTO_ADVANCE_TICKS = 16'd6000;

    typedef struct packed {
        logic [4:0]  open_intensity;
        logic [3:0]  open_mode;
        logic        open_auto_advance;
        logic [15:0] half_period_ticks;
        logic [15:0] full_period_ticks;
        logic [15:0] auto_advance_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 switched_on;
        logic                 suspended;
        logic                 auto_advance;
        logic                 phase_timer_enable;
        logic [3:0]           pattern_mode;
        logic [1:0]           pattern_phase;
        logic [4:0]           level_intensity;
        logic [PWM_CNT_W-1:0] pwm_count;
        logic [15:0]          phase_timer;
        logic [15:0]          advance_timer;
        logic [1:0]           pattern_a_b;
        logic [1:0]           drive_a_b;
    } state_t;

    typedef struct packed {
        logic motor_a_drive;
        logic motor_b_drive;
        logic run_status;
        logic status_code;
    } result_t;

endpackage

/* hw/rtl/dmp_step.sv */
module dmp_step
    import dmp_pkg::*;
#(
    parameter int unsigned PWM_WRAP = 13
)
(
    input  state_t     state_cur,
    input  cfg_t       cfg,
    input  logic [3:0] command,
    input  logic [7:0] value,
    output state_t     state_next,
    output result_t    result
);

    always_comb
    begin
        state_t                 nx;
        logic [PWM_CNT_W:0]     cnt_inc;
        logic                   status;
        nx      = state_cur;
        status  = STATUS_OK;
        cnt_inc = {1'b0, state_cur.pwm_count} + {{PWM_CNT_W{1'b0}}, 1'b1};

        case (command)
            CMD_TICK:
            begin
                if (state_cur.switched_on && !state_cur.suspended)
                begin
                    if (cnt_inc < {1'b0, state_cur.level_intensity})
                    begin
                        nx.pwm_count = cnt_inc[PWM_CNT_W-1:0];
                        nx.drive_a_b = state_cur.pattern_a_b;
                    end
                    else
                    begin
                        nx.drive_a_b = 2'b00;
                        if (cnt_inc > (PWM_CNT_W+1)'(PWM_WRAP))
                            nx.pwm_count = '0;
                        else
                            nx.pwm_count = cnt_inc[PWM_CNT_W-1:0];
                    end
                    if (state_cur.phase_timer_enable)
                        nx.phase_timer = state_cur.phase_timer + 16'd1;
                    if (state_cur.auto_advance)
                        nx.advance_timer = state_cur.advance_timer + 16'd1;
                end
            end
            CMD_POLL:
            begin
                // Automatic advance runs first; the pattern logic then sees the new mode.
                if (state_cur.auto_advance &&
                    state_cur.advance_timer > cfg.auto_advance_ticks)
                begin
                    nx.advance_timer = '0;
                    nx.phase_timer   = '0;
                    if (state_cur.pattern_mode > MODE_PULSE)
                    begin
                        nx.pattern_phase = '0;
                        nx.pattern_mode  = MODE_STEP;
                    end
                    else
                    begin
                        nx.pattern_mode = state_cur.pattern_mode + 4'd1;
                    end
                end
                case (nx.pattern_mode)
                    MODE_STEP:
                    begin
                        nx.phase_timer_enable = 1'b1;
                        if (nx.phase_timer > cfg.half_period_ticks)
                        begin
                            nx.phase_timer = '0;
                            if (nx.pattern_phase >= 2'd2)
                                nx.pattern_phase = 2'd0;
                            else
                                nx.pattern_phase = nx.pattern_phase + 2'd1;
                            nx.pattern_a_b = {nx.pattern_phase == 2'd1,
                                              nx.pattern_phase == 2'd0};
                        end
                    end
                    MODE_ALT:
                    begin
                        nx.phase_timer_enable = 1'b1;
                        if (nx.phase_timer > cfg.full_period_ticks)
                        begin
                            nx.phase_timer   = '0;
                            nx.pattern_phase = (nx.pattern_phase != 2'd0) ? 2'd0 : 2'd1;
                            nx.pattern_a_b   = (nx.pattern_phase != 2'd0) ? 2'b01 : 2'b10;
                        end
                    end
                    MODE_PULSE:
                    begin
                        nx.phase_timer_enable = 1'b1;
                        if (nx.phase_timer > cfg.full_period_ticks)
                        begin
                            nx.phase_timer   = '0;
                            nx.pattern_phase = (nx.pattern_phase != 2'd0) ? 2'd0 : 2'd1;
                            nx.pattern_a_b   = (nx.pattern_phase != 2'd0) ? 2'b11 : 2'b00;
                        end
                    end
                    default:
                    begin
                        nx.pattern_mode = MODE_STEP;
                    end
                endcase
            end
            CMD_OPEN:
            begin
                nx.level_intensity = cfg.open_intensity;
                nx.pattern_mode    = cfg.open_mode;
                nx.suspended       = 1'b0;
                nx.switched_on     = 1'b1;
                nx.auto_advance    = cfg.open_auto_advance;
            end
            CMD_CLOSE:
            begin
                nx.switched_on = 1'b0;
                nx.drive_a_b   = 2'b00;
            end
            CMD_SUSPEND:
            begin
                nx.suspended = 1'b1;
                nx.drive_a_b = 2'b00;
            end
            CMD_RESUME:
            begin
                nx.suspended = 1'b0;
            end
            CMD_SET_MODE:
            begin
                nx.pattern_mode = value[3:0];
            end
            CMD_SET_INTENSITY:
            begin
                nx.level_intensity = value[4:0];
            end
            CMD_STATUS:
            begin
                nx.drive_a_b = state_cur.drive_a_b;
            end
            default:
            begin
                status = STATUS_UNKNOWN;
            end
        endcase

        state_next           = nx;
        result.motor_a_drive = nx.drive_a_b[0];
        result.motor_b_drive = nx.drive_a_b[1];
        result.run_status    = nx.switched_on && !nx.suspended;
        result.status_code   = status;
    end

endmodule

/* hw/rtl/dual_motor_pattern_pwm_controller_top.sv */
// Two-motor pattern driver with a PWM gate on intensity, one channel.
// Input channel: in_valid/in_ready carries one command and an 8-bit value per
// transfer. Output channel: out_valid/out_ready carries one result per command:
// the two motor drive levels, the run status and a status code.
// Configuration: cfg_we, cfg_index and cfg_data write one of six registers.
// Writes are expected only while no command is in flight.
// Result: a command accepted at one clock edge has its result on the output
// registers after that edge. Throughput: one command per cycle while out_ready
// stays high. The whole state update is a single pass of combinational logic in
// the step unit, between the state registers and the result register.
// Stalls: in_ready stays high while the result register is empty or is being
// drained in the same cycle. When the receiver holds out_ready low, the result
// is kept and in_ready drops until it is taken, so no result is lost.
// Reset: rst_n clears all state, empties the result register and loads the
// configuration registers with their default values.
`include "assert_macros.svh"

module dual_motor_pattern_pwm_controller_top
    import dmp_pkg::*;
#(
    parameter int unsigned PWM_WRAP = 13
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           command,
    input  logic [7:0]           value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 motor_a_drive,
    output logic                 motor_b_drive,
    output logic                 run_status,
    output logic                 status_code
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    accept;

    // A new command may enter whenever the result register is free or drains now.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration registers. Indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_intensity     <= RST_OPEN_INTENSITY;
            cfg_reg.open_mode          <= RST_OPEN_MODE;
            cfg_reg.open_auto_advance  <= RST_OPEN_AUTO_ADVANCE;
            cfg_reg.half_period_ticks  <= RST_HALF_PERIOD_TICKS;
            cfg_reg.full_period_ticks  <= RST_FULL_PERIOD_TICKS;
            cfg_reg.auto_advance_ticks <= RST_AUTO_ADVANCE_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OPEN_INTENSITY:     cfg_reg.open_intensity     <= cfg_data[4:0];
                REG_OPEN_MODE:          cfg_reg.open_mode          <= cfg_data[3:0];
                REG_OPEN_AUTO_ADVANCE:  cfg_reg.open_auto_advance  <= cfg_data[0];
                REG_HALF_PERIOD_TICKS:  cfg_reg.half_period_ticks  <= cfg_data;
                REG_FULL_PERIOD_TICKS:  cfg_reg.full_period_ticks  <= cfg_data;
                REG_AUTO_ADVANCE_TICKS: cfg_reg.auto_advance_ticks <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The step unit holds all of the command decoding and pattern logic.
    dmp_step #(
        .PWM_WRAP (PWM_WRAP)
    ) u_step (
        .state_cur  (state_reg),
        .cfg        (cfg_reg),
        .command    (command),
        .value      (value),
        .state_next (state_next),
        .result     (result_next)
    );

    // State advances only on an accepted command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_a_drive = result_reg.motor_a_drive;
    assign motor_b_drive = result_reg.motor_b_drive;
    assign run_status    = result_reg.run_status;
    assign status_code   = result_reg.status_code;

    // Every accepted command leaves a result behind.
    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_reg)

    // Close forces both motors off in the result it produces.
    `ASSERT_NEXT(a_close_drives_low, clk, rst_n, accept && (command == CMD_CLOSE),
                 !motor_a_drive && !motor_b_drive && !run_status)

    // A tick while the channel is not running leaves the drive levels untouched.
    `ASSERT_NEXT(a_idle_tick_holds_drive, clk, rst_n,
                 accept && (command == CMD_TICK) &&
                 !(state_reg.switched_on && !state_reg.suspended),
                 $stable(state_reg.drive_a_b))

    // The phase only ever takes the values zero, one and two.
    `ASSERT_IMPLIES(a_phase_in_range, clk, rst_n, 1'b1, state_reg.pattern_phase != 2'd3)

endmodule

/* dv/dmp_response_checker.sv */
module dmp_response_checker
    import dmp_pkg::*;
#(
    parameter int unsigned PWM_WRAP = 13
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [3:0]           command,
    input  logic [7:0]           value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 motor_a_drive,
    input  logic                 motor_b_drive,
    input  logic                 run_status,
    input  logic                 status_code,
    output int unsigned          fail_count,
    output int unsigned          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic [4:0]  open_level;
    logic [3:0]  open_pattern;
    logic        open_auto;
    logic [15:0] half_limit;
    logic [15:0] full_limit;
    logic [15:0] advance_limit;

    // Shadow copy of the controller state.
    logic        powered;
    logic        paused;
    logic        auto_on;
    logic        phase_count_on;
    logic [3:0]  mode;
    logic [1:0]  phase;
    logic [4:0]  level;
    logic [5:0]  pwm_tick;
    logic [15:0] phase_count;
    logic [15:0] advance_count;
    logic [1:0]  pattern_ab;
    logic [1:0]  drive_ab;

    result_t motor_response_q[$];

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_OPEN_INTENSITY:     open_level    = data[4:0];
            REG_OPEN_MODE:          open_pattern  = data[3:0];
            REG_OPEN_AUTO_ADVANCE:  open_auto     = data[0];
            REG_HALF_PERIOD_TICKS:  half_limit    = data[15:0];
            REG_FULL_PERIOD_TICKS:  full_limit    = data[15:0];
            REG_AUTO_ADVANCE_TICKS: advance_limit = data[15:0];
            default: ;
        endcase
    endtask

    task automatic pwm_tick_step();
        if (powered && !paused)
        begin
            pwm_tick = pwm_tick + 6'd1;
            if (pwm_tick < {1'b0, level})
            begin
                drive_ab = pattern_ab;
            end
            else
            begin
                drive_ab = 2'b00;
                if (pwm_tick > PWM_WRAP)
                begin
                    pwm_tick = '0;
                end
            end
            if (phase_count_on)
            begin
                phase_count = phase_count + 16'd1;
            end
            if (auto_on)
            begin
                advance_count = advance_count + 16'd1;
            end
        end
    endtask

    task automatic pattern_poll_step();
        if (auto_on && advance_count > advance_limit)
        begin
            advance_count = '0;
            phase_count = '0;
            if (mode > MODE_PULSE)
            begin
                phase = 2'd0;
                mode = MODE_STEP;
            end
            else
            begin
                mode = mode + 4'd1;
            end
        end
        case (mode)
            MODE_STEP:
            begin
                phase_count_on = 1'b1;
                if (phase_count > half_limit)
                begin
                    phase_count = '0;
                    phase = (phase >= 2'd2) ? 2'd0 : phase + 2'd1;
                    pattern_ab = {phase == 2'd1, phase == 2'd0};
                end
            end
            MODE_ALT:
            begin
                phase_count_on = 1'b1;
                if (phase_count > full_limit)
                begin
                    phase = (phase != 2'd0) ? 2'd0 : 2'd1;
                    pattern_ab = (phase != 2'd0) ? 2'b01 : 2'b10;
                    phase_count = '0;
                end
            end
            MODE_PULSE:
            begin
                phase_count_on = 1'b1;
                if (phase_count > full_limit)
                begin
                    phase_count = '0;
                    phase = (phase != 2'd0) ? 2'd0 : 2'd1;
                    pattern_ab = (phase != 2'd0) ? 2'b11 : 2'b00;
                end
            end
            default: mode = MODE_STEP;
        endcase
    endtask

    task automatic step_motor_controller(input logic [3:0] cmd, input logic [7:0] val,
                                         output result_t res);
        logic status;
        status = STATUS_OK;
        case (cmd)
            CMD_TICK: pwm_tick_step();
            CMD_POLL: pattern_poll_step();
            CMD_OPEN:
            begin
                level = open_level;
                mode = open_pattern;
                paused = 1'b0;
                powered = 1'b1;
                auto_on = open_auto;
            end
            CMD_CLOSE:
            begin
                powered = 1'b0;
                drive_ab = 2'b00;
            end
            CMD_SUSPEND:
            begin
                paused = 1'b1;
                drive_ab = 2'b00;
            end
            CMD_RESUME:        paused = 1'b0;
            CMD_SET_MODE:      mode = val[3:0];
            CMD_SET_INTENSITY: level = val[4:0];
            CMD_STATUS:        ;
            default:           status = STATUS_UNKNOWN;
        endcase
        res.motor_a_drive = drive_ab[0];
        res.motor_b_drive = drive_ab[1];
        res.run_status    = powered && !paused;
        res.status_code   = status;
    endtask

    task automatic check_field(input string name, input logic exp_bit, input logic got_bit);
        if (got_bit !== exp_bit)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_bit, got_bit);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t predicted;
        result_t observed;
        if (!rst_n)
        begin
            open_level     = RST_OPEN_INTENSITY;
            open_pattern   = RST_OPEN_MODE;
            open_auto      = RST_OPEN_AUTO_ADVANCE;
            half_limit     = RST_HALF_PERIOD_TICKS;
            full_limit     = RST_FULL_PERIOD_TICKS;
            advance_limit  = RST_AUTO_ADVANCE_TICKS;
            powered        = 1'b0;
            paused         = 1'b0;
            auto_on        = 1'b0;
            phase_count_on = 1'b0;
            mode           = '0;
            phase          = '0;
            level          = '0;
            pwm_tick       = '0;
            phase_count    = '0;
            advance_count  = '0;
            pattern_ab     = '0;
            drive_ab       = '0;
            motor_response_q.delete();
            fail_count     = 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                write_setting(cfg_index, cfg_data);
            end
            // The result leaving this edge was predicted earlier, so pop before pushing.
            if (out_valid && out_ready)
            begin
                observed = {motor_a_drive, motor_b_drive, run_status, status_code};
                if (motor_response_q.size() == 0)
                begin
                    $display("%0t: result with no expectation, expected none, actual %b",
                             $time, observed);
                    fail_count++;
                end
                else
                begin
                    predicted = motor_response_q.pop_front();
                    check_field("motor_a_drive", predicted.motor_a_drive, observed.motor_a_drive);
                    check_field("motor_b_drive", predicted.motor_b_drive, observed.motor_b_drive);
                    check_field("run_status", predicted.run_status, observed.run_status);
                    check_field("status_code", predicted.status_code, observed.status_code);
                end
            end
            if (in_valid && in_ready)
            begin
                step_motor_controller(command, value, predicted);
                motor_response_q.push_back(predicted);
            end
            pending <= motor_response_q.size();
        end
    end

endmodule

/* dv/tb_dual_motor_pattern_pwm_controller_top.sv */
module tb_dual_motor_pattern_pwm_controller_top
    import dmp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PWM_WRAP      = 13;
    // The slowest legal run stays well under this limit, which leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int unsigned LONG_HOLD     = 60;
    localparam int unsigned PHASE_ITEMS   = 75;
    // Command codes past the defined set; the block must flag them as unknown.
    localparam logic [3:0]  CMD_UNKNOWN_LO = 4'd9;
    localparam logic [3:0]  CMD_UNKNOWN_HI = 4'd15;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [3:0]           command;
    logic [7:0]           value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 motor_a_drive;
    logic                 motor_b_drive;
    logic                 run_status;
    logic                 status_code;

    int unsigned mismatch_count;
    int unsigned pending_results;

    // Set by the stimulus process: hold_request asks the receiver for one long
    // hold-off, and calm turns off all idling for the final stretch of the run.
    logic hold_request;
    logic calm;

    dual_motor_pattern_pwm_controller_top #(
        .PWM_WRAP(PWM_WRAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .motor_a_drive(motor_a_drive),
        .motor_b_drive(motor_b_drive),
        .run_status(run_status),
        .status_code(status_code)
    );

    // The checker sits beside the block, watches every transfer on both
    // channels and every register write, and reports mismatches and the number
    // of results still outstanding.
    dmp_response_checker #(
        .PWM_WRAP(PWM_WRAP)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .motor_a_drive(motor_a_drive),
        .motor_b_drive(motor_b_drive),
        .run_status(run_status),
        .status_code(status_code),
        .fail_count(mismatch_count),
        .pending(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: if the run has not finished by the limit, something is hung.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_dual_motor_pattern_pwm_controller_top NOT OK");
        $finish;
    end

    // Receiver side. Most of the time out_ready is high, but it drops in random
    // bursts so that stalls land on every part of the command stream. Once in
    // the run it holds off for a long stretch while the sender keeps offering
    // commands, which fills the result register and forces in_ready low.
    initial
    begin : receiver
        int unsigned stall;
        logic hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 12);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one command and returns at the edge where its transfer happens.
    // A random gap may come first; back-to-back commands keep in_valid high so
    // it is never dropped and raised again within one time step.
    task automatic send_command(input logic [3:0] cmd, input logic [7:0] val);
        int unsigned gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do @(posedge clk); while (!in_ready);
    endtask

    // Lets the block drain completely. The extra edge makes sure the checker
    // has already counted the last command before its outstanding count is read.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Loads all six configuration registers; only called while the block is idle.
    task automatic program_settings(input logic [4:0] intensity, input logic [3:0] mode,
                                    input logic auto_adv, input logic [15:0] half_ticks,
                                    input logic [15:0] full_ticks,
                                    input logic [15:0] adv_ticks);
        write_register(REG_OPEN_INTENSITY, CFG_W'(intensity));
        write_register(REG_OPEN_MODE, CFG_W'(mode));
        write_register(REG_OPEN_AUTO_ADVANCE, CFG_W'(auto_adv));
        write_register(REG_HALF_PERIOD_TICKS, half_ticks);
        write_register(REG_FULL_PERIOD_TICKS, full_ticks);
        write_register(REG_AUTO_ADVANCE_TICKS, adv_ticks);
        cfg_we <= 1'b0;
    endtask

    // Random command mix. Ticks and polls dominate so that the PWM counter, the
    // phase timer and the advance timer actually move; opens outnumber closes
    // and suspends so the channel is running most of the time. Set-mode values
    // lean toward the three valid patterns but still hit the invalid ones.
    task automatic pick_command(output logic [3:0] cmd, output logic [7:0] val);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        val  = 8'($urandom_range(0, 255));
        if (roll < 48)
        begin
            cmd = CMD_TICK;
        end
        else if (roll < 70)
        begin
            cmd = CMD_POLL;
        end
        else if (roll < 75)
        begin
            cmd = CMD_OPEN;
        end
        else if (roll < 77)
        begin
            cmd = CMD_CLOSE;
        end
        else if (roll < 79)
        begin
            cmd = CMD_SUSPEND;
        end
        else if (roll < 83)
        begin
            cmd = CMD_RESUME;
        end
        else if (roll < 88)
        begin
            cmd = CMD_SET_MODE;
            if ($urandom_range(0, 3) != 0)
            begin
                val[3:0] = 4'($urandom_range(MODE_STEP, MODE_PULSE));
            end
        end
        else if (roll < 93)
        begin
            cmd = CMD_SET_INTENSITY;
        end
        else if (roll < 96)
        begin
            cmd = CMD_STATUS;
        end
        else
        begin
            cmd = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        end
    endtask

    // Every phase opens the channel first so the new open settings take effect,
    // then runs a stream of random commands.
    task automatic run_phase(input int unsigned n_items);
        logic [3:0] cmd;
        logic [7:0] val;
        send_command(CMD_OPEN, 8'($urandom_range(0, 255)));
        repeat (n_items - 1)
        begin
            pick_command(cmd, val);
            send_command(cmd, val);
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        in_valid     <= 1'b0;
        command      <= CMD_STATUS;
        value        <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_OPEN_INTENSITY;
        cfg_data     <= '0;
        hold_request <= 1'b0;
        calm         <= 1'b0;
        rst_n        <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: status and tick while closed, a poll
        // in the invalid reset mode, unknown codes at both ends of their range,
        // then an open with the default settings and a fallback from mode 0.
        send_command(CMD_STATUS, 8'h00);
        send_command(CMD_TICK, 8'hFF);
        send_command(CMD_POLL, 8'h00);
        send_command(CMD_UNKNOWN_LO, 8'h55);
        send_command(CMD_UNKNOWN_HI, 8'hAA);
        send_command(CMD_OPEN, 8'h00);
        send_command(CMD_TICK, 8'h00);
        send_command(CMD_SET_MODE, 8'hF0);
        send_command(CMD_POLL, 8'hFF);
        wait_drained();

        // Directed part, short periods: the pulse pattern switches on after one
        // tick, auto advance steps the mode past 3 into the fallback, and suspend
        // and close cut the drive at once, with a resume in between.
        program_settings(5'd31, MODE_PULSE, 1'b1, 16'd1, 16'd0, 16'd2);
        send_command(CMD_OPEN, 8'h00);
        send_command(CMD_POLL, 8'h00);
        send_command(CMD_TICK, 8'h00);
        send_command(CMD_POLL, 8'h00);
        send_command(CMD_TICK, 8'h00);
        send_command(CMD_TICK, 8'h00);
        send_command(CMD_TICK, 8'h00);
        send_command(CMD_POLL, 8'h00);
        send_command(CMD_SUSPEND, 8'h00);
        send_command(CMD_TICK, 8'h00);
        send_command(CMD_RESUME, 8'h00);
        send_command(CMD_SET_MODE, 8'h02);
        send_command(CMD_CLOSE, 8'h00);
        send_command(CMD_SET_INTENSITY, 8'hFF);
        send_command(CMD_STATUS, 8'hFF);
        wait_drained();

        // Random phases, each under its own settings. The first ones use the
        // smallest periods and limits so the patterns change often.
        program_settings(5'd31, MODE_STEP, 1'b0, 16'd0, 16'd0, 16'd0);
        run_phase(PHASE_ITEMS);

        program_settings(5'd0, 4'd15, 1'b1, 16'd2, 16'd3, 16'd5);
        run_phase(PHASE_ITEMS);

        // This phase carries the long receiver hold-off.
        program_settings(5'd7, MODE_ALT, 1'b1, 16'd1, 16'd1, 16'd20);
        hold_request <= 1'b1;
        run_phase(PHASE_ITEMS);

        // Largest limits: no phase change and no auto advance can happen.
        program_settings(5'd14, MODE_PULSE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_ITEMS);

        program_settings(5'd20, 4'd0, 1'b1, 16'd4, 16'd2, 16'd0);
        run_phase(PHASE_ITEMS);

        // Final stretch: random small settings and no idling on either side.
        program_settings(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 8)),
                         16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)));
        calm <= 1'b1;
        run_phase(PHASE_ITEMS);

        // Everything has been accepted and drained; give the block a few more
        // cycles in case a stray result is still on its way out.
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("tb_dual_motor_pattern_pwm_controller_top OK");
        end
        else
        begin
            $display("tb_dual_motor_pattern_pwm_controller_top NOT OK");
        end
        $finish;
    end

endmodule
